// ===== hdl/rlp_enc_pkg.sv =====
`timescale 1ns / 1ps

package rlp_enc_pkg;

  // request function codes
  localparam logic [2:0] FN_PUSH     = 3'd0;
  localparam logic [2:0] FN_FIN_STR  = 3'd1;
  localparam logic [2:0] FN_FIN_INT  = 3'd2;
  localparam logic [2:0] FN_HDR_STR  = 3'd3;
  localparam logic [2:0] FN_HDR_LIST = 3'd4;

  localparam logic [7:0] OFS_STRING  = 8'h80;
  localparam logic [7:0] OFS_LIST    = 8'hC0;
  localparam logic [7:0] SHORT_LIMIT = 8'd56;
  localparam logic [7:0] LONG_BASE   = 8'd55;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_HEAD,
    EM_LEN,
    EM_PAY
  } emit_e;

  typedef struct packed {
    logic  push;
    logic  load;
    emit_e emit;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic nlen_zero;
    logic nlen_one;
    logic pay_zero;
    logic pay_one;
  } status_t;

endpackage

// ===== hdl/rlp_item_encoder.sv =====
// RLP item encoder.
// Input channel (in_valid_i / in_stall_o) carries one request per beat:
// func_i selects push byte, finish as string, finish as integer, string
// header or list header; data_byte_i and length_i carry the operands.
// Output channel (out_valid_o / out_stall_i) carries one encoded byte per
// beat, with last_o on the final byte of a run and overflow_o set on every
// byte of a finish run when pushed bytes were dropped.
// Flow: a push is accepted without stalling the input and never produces
// output. A finish or header request holds the input while its run of B
// bytes (header, length bytes, payload) goes out, one byte per cycle from
// the output register while the receiver does not stall; the payload is read
// from the item buffer RAM one address per cycle under the same condition.
// A stalled receiver holds the output register and freezes the run; the
// input stays stalled until the last byte has been loaded.
// Reset clears the byte count and the overflow flag; the buffer RAM is not
// cleared and needs no clearing pass.
`timescale 1ns / 1ps

module rlp_item_encoder import rlp_enc_pkg::*; #(
  parameter int MAX_ITEM_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        overflow_o
);

  cmd_t    cmd;
  status_t status;

  rlp_enc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rlp_enc_dp #(
    .MAX_ITEM_BYTES (MAX_ITEM_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .length_i    (length_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

`ifndef NO_ASSERTIONS
  // a byte on offer that is not the last of its run means the run is still going
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |-> in_stall_o)
    else $error("input freed before run finished");

  // a push never starts an output run
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FN_PUSH |=> !in_stall_o)
    else $error("push request stalled the input");

  // a finish or header request always starts a run
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FN_FIN_STR || func_i == FN_FIN_INT ||
    func_i == FN_HDR_STR || func_i == FN_HDR_LIST) |=> in_stall_o)
    else $error("encode request did not start a run");
`endif

endmodule

// ===== hdl/rlp_enc_ctrl.sv =====
`timescale 1ns / 1ps

module rlp_enc_ctrl import rlp_enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] func_i,
  output logic       in_stall_o,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_LEN  = 2'd2;
  localparam logic [1:0] S_PAY  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       acc;

  assign in_stall_o = (state_q != S_IDLE);
  assign acc        = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o.push  = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.emit  = EM_NONE;
    cmd_o.last  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (func_i) inside
            FN_PUSH: cmd_o.push = 1'b1;
            FN_FIN_STR, FN_FIN_INT, FN_HDR_STR, FN_HDR_LIST: begin
              cmd_o.load = 1'b1;
              state_d    = S_HEAD;
            end
            default: ;
          endcase
        end
      end
      S_HEAD: begin
        if (status_i.slot_free) begin
          cmd_o.emit = EM_HEAD;
          cmd_o.last = status_i.nlen_zero && status_i.pay_zero;
          if (!status_i.nlen_zero) state_d = S_LEN;
          else if (!status_i.pay_zero) state_d = S_PAY;
          else state_d = S_IDLE;
        end
      end
      S_LEN: begin
        if (status_i.slot_free) begin
          cmd_o.emit = EM_LEN;
          cmd_o.last = status_i.nlen_one && status_i.pay_zero;
          if (status_i.nlen_one) state_d = status_i.pay_zero ? S_IDLE : S_PAY;
        end
      end
      S_PAY: begin
        if (status_i.slot_free) begin
          cmd_o.emit = EM_PAY;
          cmd_o.last = status_i.pay_one;
          if (status_i.pay_one) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/rlp_enc_dp.sv =====
`timescale 1ns / 1ps

module rlp_enc_dp import rlp_enc_pkg::*; #(
  parameter int MAX_ITEM_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] length_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        overflow_o
);

  localparam int CW = $clog2(MAX_ITEM_BYTES + 1);
  localparam int AW = $clog2(MAX_ITEM_BYTES);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ITEM_BYTES);

  logic [7:0]    mem [MAX_ITEM_BYTES];
  logic [7:0]    rdata_q;

  logic [CW-1:0] count_q, lead_q;
  logic          nz_seen_q, ovf_flag_q;
  logic [7:0]    first_byte_q, first_nz_q;

  logic [7:0]    head_q;
  logic [2:0]    nlen_q;
  logic [31:0]   lbytes_q;
  logic [CW-1:0] pay_cnt_q;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic          run_ovf_q;

  logic          out_valid_q, last_q, ovf_q;
  logic [7:0]    out_byte_q, out_byte_d;

  logic          is_fin, is_int, room, raw;
  logic [CW-1:0] start, plen;
  logic [7:0]    sel_byte, ofs;
  logic [2:0]    n_hdr;
  logic [7:0]    ld_head;
  logic [2:0]    ld_nlen;
  logic [31:0]   ld_lbytes;
  logic [CW-1:0] ld_pay;

  assign is_int   = (func_i == FN_FIN_INT);
  assign is_fin   = (func_i == FN_FIN_STR) || is_int;
  assign room     = (count_q != MaxCnt);
  assign start    = is_int ? lead_q : '0;
  assign plen     = count_q - start;
  assign sel_byte = is_int ? first_nz_q : first_byte_q;
  assign raw      = (plen == CW'(1)) && (sel_byte < OFS_STRING);
  assign ofs      = (func_i == FN_HDR_LIST) ? OFS_LIST : OFS_STRING;

  always_comb begin
    if (length_i[31:24] != 8'd0) n_hdr = 3'd4;
    else if (length_i[23:16] != 8'd0) n_hdr = 3'd3;
    else if (length_i[15:8] != 8'd0) n_hdr = 3'd2;
    else n_hdr = 3'd1;
  end

  always_comb begin
    ld_head   = 8'd0;
    ld_nlen   = 3'd0;
    ld_lbytes = 32'd0;
    ld_pay    = '0;
    if (is_fin) begin
      if (raw) begin
        ld_head = sel_byte;
      end else if (8'(plen) < SHORT_LIMIT) begin
        ld_head = OFS_STRING + 8'(plen);
        ld_pay  = plen;
      end else begin
        ld_head   = OFS_STRING + LONG_BASE + 8'd1;
        ld_nlen   = 3'd1;
        ld_lbytes = {8'(plen), 24'd0};
        ld_pay    = plen;
      end
    end else if (length_i < 32'(SHORT_LIMIT)) begin
      ld_head = ofs + length_i[7:0];
    end else begin
      ld_head = ofs + LONG_BASE + 8'(n_hdr);
      ld_nlen = n_hdr;
      case (n_hdr)
        3'd1:    ld_lbytes = {length_i[7:0], 24'd0};
        3'd2:    ld_lbytes = {length_i[15:0], 16'd0};
        3'd3:    ld_lbytes = {length_i[23:0], 8'd0};
        default: ld_lbytes = length_i;
      endcase
    end
  end

  // read address runs one step ahead so rdata_q always matches rd_ptr_q
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.load) rd_ptr_d = start[AW-1:0];
    else if (cmd_i.emit == EM_PAY) rd_ptr_d = rd_ptr_q + AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && room) mem[count_q[AW-1:0]] <= data_byte_i;
    rdata_q <= mem[rd_ptr_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      lead_q     <= '0;
      nz_seen_q  <= 1'b0;
      ovf_flag_q <= 1'b0;
    end else if (cmd_i.push) begin
      if (room) begin
        count_q <= count_q + CW'(1);
        if (!nz_seen_q) begin
          if (data_byte_i == 8'd0) lead_q <= lead_q + CW'(1);
          else nz_seen_q <= 1'b1;
        end
      end else begin
        ovf_flag_q <= 1'b1;
      end
    end else if (cmd_i.load && is_fin) begin
      count_q    <= '0;
      lead_q     <= '0;
      nz_seen_q  <= 1'b0;
      ovf_flag_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && room) begin
      if (count_q == '0) first_byte_q <= data_byte_i;
      if (!nz_seen_q && data_byte_i != 8'd0) first_nz_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nlen_q    <= 3'd0;
      pay_cnt_q <= '0;
      rd_ptr_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      if (cmd_i.load) begin
        nlen_q    <= ld_nlen;
        pay_cnt_q <= ld_pay;
      end else if (cmd_i.emit == EM_LEN) begin
        nlen_q <= nlen_q - 3'd1;
      end else if (cmd_i.emit == EM_PAY) begin
        pay_cnt_q <= pay_cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      head_q    <= ld_head;
      lbytes_q  <= ld_lbytes;
      run_ovf_q <= is_fin && ovf_flag_q;
    end else if (cmd_i.emit == EM_LEN) begin
      lbytes_q <= {lbytes_q[23:0], 8'd0};
    end
  end

  always_comb begin
    case (cmd_i.emit)
      EM_HEAD: out_byte_d = head_q;
      EM_LEN:  out_byte_d = lbytes_q[31:24];
      default: out_byte_d = rdata_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit != EM_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EM_NONE) begin
      out_byte_q <= out_byte_d;
      last_q     <= cmd_i.last;
      ovf_q      <= run_ovf_q;
    end
  end

  assign status_o.slot_free = !out_valid_q || !out_stall_i;
  assign status_o.nlen_zero = (nlen_q == 3'd0);
  assign status_o.nlen_one  = (nlen_q == 3'd1);
  assign status_o.pay_zero  = (pay_cnt_q == '0);
  assign status_o.pay_one   = (pay_cnt_q == CW'(1));

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;
  assign overflow_o  = ovf_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rlp_enc_pkg::*;

  localparam int ITEM_CAP = 32;
  localparam int N_ITEMS = 420;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 100;

  // func codes the block has no use for
  localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] FN_UNUSED_LAST  = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  data;
    logic [31:0] len;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } enc_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i = FN_PUSH;
  logic [7:0]  data_byte_i = 8'h00;
  logic [31:0] length_i = 32'h0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic        overflow_o;

  request_t    req_queue [$];
  request_t    next_req;
  enc_byte_t   expected_bytes [$];
  enc_byte_t   want;
  logic [7:0]  run_bytes [$];

  // encoder state as the block should hold it
  logic [7:0]  item_mem [ITEM_CAP];
  int unsigned held_cnt = 0;
  logic        dropped = 1'b0;

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_fail = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 100;

  int unsigned kind, nbytes, nzero, sz_sel, len_class;
  logic [2:0]  fin_fn;
  logic [31:0] rlen;

  rlp_item_encoder #(
    .MAX_ITEM_BYTES(ITEM_CAP)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .data_byte_i(data_byte_i),
    .length_i   (length_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .overflow_o (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // RLP prefix for a payload of len bytes
  task automatic add_prefix(input logic [31:0] len, input logic [7:0] ofs);
    int unsigned n;
    int k;
    n = 0;
    if (len < 32'(SHORT_LIMIT)) begin
      run_bytes.push_back(ofs + len[7:0]);
    end else begin
      for (k = 0; k < 4; k++) begin
        if ((len >> (8 * k)) != 0) n = k + 1;
      end
      run_bytes.push_back(ofs + LONG_BASE + 8'(n));
      for (k = n; k > 0; k--) begin
        run_bytes.push_back(len[8 * (k - 1) +: 8]);
      end
    end
  endtask

  task automatic rlp_encode(input logic [2:0] fn, input logic [7:0] dat,
                            input logic [31:0] len);
    int unsigned first;
    int i;
    logic ovf;
    enc_byte_t e;
    first = 0;
    ovf = 1'b0;
    run_bytes.delete();
    case (fn)
      FN_PUSH: begin
        if (held_cnt < ITEM_CAP) begin
          item_mem[held_cnt] = dat;
          held_cnt++;
        end else begin
          dropped = 1'b1;
        end
      end
      FN_FIN_STR, FN_FIN_INT: begin
        // integers lose their leading zero bytes
        if (fn == FN_FIN_INT) begin
          while (first < held_cnt && item_mem[first] == 8'h00) first++;
        end
        ovf = dropped;
        if (held_cnt - first == 1 && item_mem[first] < OFS_STRING) begin
          run_bytes.push_back(item_mem[first]);
        end else begin
          add_prefix(held_cnt - first, OFS_STRING);
          for (i = first; i < held_cnt; i++) run_bytes.push_back(item_mem[i]);
        end
        held_cnt = 0;
        dropped = 1'b0;
      end
      FN_HDR_STR:  add_prefix(len, OFS_STRING);
      FN_HDR_LIST: add_prefix(len, OFS_LIST);
      default: ;
    endcase
    for (i = 0; i < run_bytes.size(); i++) begin
      e.data = run_bytes[i];
      e.last = (i == run_bytes.size() - 1);
      e.ovf = ovf;
      expected_bytes.push_back(e);
    end
  endtask

  task automatic add_req(input logic [2:0] fn, input logic [7:0] dat,
                         input logic [31:0] len);
    request_t r;
    r.func = fn;
    r.data = dat;
    r.len = len;
    req_queue.push_back(r);
    if (fn <= FN_HDR_LIST) n_queued++;
  endtask

  // driver: bursts of requests with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rlp_encode(func_i, data_byte_i, length_i);
        n_accepted <= n_accepted + 1;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the request until it is taken
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (req_queue.size() != 0) begin
        next_req = req_queue.pop_front();
        func_i <= next_req.func;
        data_byte_i <= next_req.data;
        length_i <= next_req.len;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off, so the block backs up into its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (n_accepted >= next_hold_at) begin
        hold_left <= HOLD_CYCLES;
        next_hold_at <= next_hold_at + 200;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      case (stall_mode_e'(cycle_cnt[8:7]))
        STALL_NONE:  out_stall_i <= (hold_left != 0);
        STALL_LIGHT: out_stall_i <= (hold_left != 0) || ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= (hold_left != 0) || ($urandom_range(0, 9) < 7);
        default:     out_stall_i <= (hold_left != 0) || (cycle_cnt[1:0] == 2'd0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        n_fail <= n_fail + 1;
        if (n_fail < MAX_REPORTS)
          $display("%0t: unexpected byte: expected none, got byte %h last %b overflow %b",
                   $realtime, out_byte_o, last_o, overflow_o);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.data || last_o !== want.last || overflow_o !== want.ovf) begin
          n_fail <= n_fail + 1;
          if (n_fail < MAX_REPORTS)
            $display("%0t: mismatch: expected %h last %b ovf %b, got %h last %b ovf %b",
                     $realtime, want.data, want.last, want.ovf, out_byte_o, last_o, overflow_o);
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    // empty, all-zero and single-byte items
    add_req(FN_FIN_STR, 8'($urandom_range(0, 255)), $urandom());
    add_req(FN_FIN_INT, 8'($urandom_range(0, 255)), $urandom());
    add_req(FN_PUSH, 8'h00, $urandom());
    add_req(FN_FIN_INT, 8'($urandom_range(0, 255)), $urandom());
    add_req(FN_PUSH, 8'h7F, $urandom());
    add_req(FN_FIN_STR, 8'($urandom_range(0, 255)), $urandom());
    add_req(FN_PUSH, 8'h80, $urandom());
    add_req(FN_FIN_STR, 8'($urandom_range(0, 255)), $urandom());
    add_req(FN_PUSH, 8'h00, $urandom());
    add_req(FN_PUSH, 8'h05, $urandom());
    add_req(FN_FIN_INT, 8'($urandom_range(0, 255)), $urandom());
    add_req(FN_PUSH, 8'hFF, $urandom());
    add_req(FN_PUSH, 8'h00, $urandom());
    add_req(FN_FIN_INT, 8'($urandom_range(0, 255)), $urandom());
    // header boundaries, short and long forms
    add_req(FN_HDR_STR, 8'($urandom_range(0, 255)), 32'd0);
    add_req(FN_HDR_STR, 8'($urandom_range(0, 255)), 32'd55);
    add_req(FN_HDR_STR, 8'($urandom_range(0, 255)), 32'd56);
    add_req(FN_HDR_STR, 8'($urandom_range(0, 255)), 32'hFFFF_FFFF);
    add_req(FN_HDR_LIST, 8'($urandom_range(0, 255)), 32'd0);
    add_req(FN_HDR_LIST, 8'($urandom_range(0, 255)), 32'd55);
    add_req(FN_HDR_LIST, 8'($urandom_range(0, 255)), 32'h0000_0100);
    add_req(FN_HDR_LIST, 8'($urandom_range(0, 255)), 32'h0001_0000);
    add_req(FN_HDR_LIST, 8'($urandom_range(0, 255)), 32'h0100_0000);
    add_req(3'(FN_UNUSED_FIRST + $urandom_range(0, 2)), 8'($urandom_range(0, 255)),
            $urandom());
    add_req(FN_UNUSED_LAST, 8'($urandom_range(0, 255)), $urandom());
    add_req(FN_UNUSED_FIRST, 8'($urandom_range(0, 255)), $urandom());

    while (n_queued < N_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // a whole item: pushes then a finish
        sz_sel = $urandom_range(0, 9);
        if (sz_sel < 6) nbytes = $urandom_range(0, 6);
        else if (sz_sel < 9) nbytes = $urandom_range(7, ITEM_CAP);
        else nbytes = $urandom_range(ITEM_CAP + 1, ITEM_CAP + 6);
        fin_fn = $urandom_range(0, 1) ? FN_FIN_INT : FN_FIN_STR;
        nzero = (fin_fn == FN_FIN_INT) ? $urandom_range(0, 3) : 0;
        for (int i = 0; i < nbytes; i++) begin
          add_req(FN_PUSH, (i < nzero) ? 8'h00 : 8'($urandom_range(0, 255)), $urandom());
        end
        add_req(fin_fn, 8'($urandom_range(0, 255)), $urandom());
      end else if (kind < 80) begin
        len_class = $urandom_range(0, 4);
        case (len_class)
          0: rlen = $urandom_range(0, 55);
          1: rlen = $urandom_range(56, 255);
          2: rlen = $urandom_range(32'h100, 32'hFFFF);
          3: rlen = $urandom_range(32'h1_0000, 32'hFF_FFFF);
          default: rlen = $urandom_range(32'h100_0000, 32'hFFFF_FFFF);
        endcase
        add_req($urandom_range(0, 1) ? FN_HDR_LIST : FN_HDR_STR,
                8'($urandom_range(0, 255)), rlen);
      end else if (kind < 88) begin
        add_req(FN_PUSH, 8'($urandom_range(0, 255)), $urandom());
      end else if (kind < 93) begin
        add_req(3'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST)),
                8'($urandom_range(0, 255)), $urandom());
      end else begin
        add_req($urandom_range(0, 1) ? FN_FIN_INT : FN_FIN_STR,
                8'($urandom_range(0, 255)), $urandom());
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rlp_enc_pkg.sv
hdl/rlp_enc_ctrl.sv
hdl/rlp_enc_dp.sv
hdl/rlp_item_encoder.sv
tb/tb.sv
